// ----- rtl/core/circle_box_collision_push_out_defines.svh -----
// Assertion helpers for the collision block.
`ifndef CIRCLE_BOX_COLLISION_PUSH_OUT_DEFINES_SVH
`define CIRCLE_BOX_COLLISION_PUSH_OUT_DEFINES_SVH

// Clocked check, off while reset is high.
`define CBC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("cbc check failed");

// Clocked check that also holds across reset.
`define CBC_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("cbc reset check failed");

`endif

// ----- rtl/core/cbc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package cbc_pkg;

  localparam int POS_W  = 24;
  localparam int VEL_W  = 20;
  localparam int SIZE_W = 12;
  localparam int RAD_W  = 20;
  localparam int FRAC_W = 8;
  localparam int ACC_W  = 26;
  localparam int MAG_W  = 25;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int D2_W   = 2 * RAD_W;
  localparam int ROOT_W = RAD_W;
  localparam int NUM_W  = 2 * RAD_W;
  localparam int SUM_W  = NUM_W + 2;

  typedef struct packed {
    logic signed [VEL_W-1:0] vx;
    logic signed [VEL_W-1:0] vy;
    logic                    sx;
    logic                    sy;
    logic                    hit;
    logic                    emb;
  } cbc_vel_t;

  typedef struct packed {
    cbc_vel_t           vel;
    logic [RAD_W-1:0]   mag_x;
    logic [RAD_W-1:0]   mag_y;
    logic [RAD_W-1:0]   radius;
  } cbc_geo_t;

endpackage
`default_nettype wire

// ----- rtl/core/cbc_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module cbc_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic signed [cbc_pkg::POS_W-1:0]    circle_x,
  input  logic signed [cbc_pkg::POS_W-1:0]    circle_y,
  input  logic signed [cbc_pkg::VEL_W-1:0]    vel_x,
  input  logic signed [cbc_pkg::VEL_W-1:0]    vel_y,
  input  logic        [cbc_pkg::SIZE_W-1:0]   circle_w,
  input  logic        [cbc_pkg::SIZE_W-1:0]   circle_h,
  input  logic signed [cbc_pkg::POS_W-1:0]    box_x,
  input  logic signed [cbc_pkg::POS_W-1:0]    box_y,
  input  logic        [cbc_pkg::SIZE_W-1:0]   box_w,
  input  logic        [cbc_pkg::SIZE_W-1:0]   box_h,
  input  logic        [cbc_pkg::RAD_W-1:0]    radius,
  output logic                                out_valid,
  output logic        [cbc_pkg::D2_W-1:0]     d2,
  output cbc_pkg::cbc_geo_t                   geo
);
  import cbc_pkg::*;

  localparam int PX = ACC_W - POS_W;
  localparam int VX = ACC_W - VEL_W;
  localparam int HX = ACC_W - SIZE_W + 1 - FRAC_W;
  localparam int BX = ACC_W - SIZE_W - FRAC_W;

  // stage 1: center and box edges
  logic                    v1;
  logic signed [ACC_W-1:0] pcx1, pcy1, lox1, hix1, loy1, hiy1;
  logic signed [VEL_W-1:0] vx1, vy1;
  logic [RAD_W-1:0]        r1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_valid;
    if (en) begin
      pcx1 <= {{PX{circle_x[POS_W-1]}}, circle_x} + {{VX{vel_x[VEL_W-1]}}, vel_x}
            + $signed({{HX{1'b0}}, circle_w[SIZE_W-1:1], {FRAC_W{1'b0}}});
      pcy1 <= {{PX{circle_y[POS_W-1]}}, circle_y} + {{VX{vel_y[VEL_W-1]}}, vel_y}
            + $signed({{HX{1'b0}}, circle_h[SIZE_W-1:1], {FRAC_W{1'b0}}});
      lox1 <= {{PX{box_x[POS_W-1]}}, box_x};
      loy1 <= {{PX{box_y[POS_W-1]}}, box_y};
      hix1 <= {{PX{box_x[POS_W-1]}}, box_x} + $signed({{BX{1'b0}}, box_w, {FRAC_W{1'b0}}});
      hiy1 <= {{PX{box_y[POS_W-1]}}, box_y} + $signed({{BX{1'b0}}, box_h, {FRAC_W{1'b0}}});
      vx1  <= vel_x;
      vy1  <= vel_y;
      r1   <= radius;
    end
  end

  // stage 2: offset magnitude and sign to the clamped point
  logic                    v2, sx2, sy2;
  logic [MAG_W-1:0]        mx2, my2;
  logic signed [VEL_W-1:0] vx2, vy2;
  logic [RAD_W-1:0]        r2;
  logic                    ltx, gtx, lty, gty;
  logic signed [ACC_W-1:0] dlx, dhx, dly, dhy;

  assign ltx = pcx1 < lox1;
  assign gtx = pcx1 > hix1;
  assign lty = pcy1 < loy1;
  assign gty = pcy1 > hiy1;
  assign dlx = lox1 - pcx1;
  assign dhx = pcx1 - hix1;
  assign dly = loy1 - pcy1;
  assign dhy = pcy1 - hiy1;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
    if (en) begin
      mx2 <= ltx ? dlx[MAG_W-1:0] : (gtx ? dhx[MAG_W-1:0] : '0);
      my2 <= lty ? dly[MAG_W-1:0] : (gty ? dhy[MAG_W-1:0] : '0);
      sx2 <= gtx;
      sy2 <= gty;
      vx2 <= vx1;
      vy2 <= vy1;
      r2  <= r1;
    end
  end

  // stage 3: squares
  logic                    v3, sx3, sy3;
  logic [SQ_W-1:0]         sqx3, sqy3;
  logic [D2_W-1:0]         rsq3;
  logic [RAD_W-1:0]        mx3, my3, r3;
  logic signed [VEL_W-1:0] vx3, vy3;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
    if (en) begin
      sqx3 <= mx2 * mx2;
      sqy3 <= my2 * my2;
      rsq3 <= r2 * r2;
      mx3  <= mx2[RAD_W-1:0];
      my3  <= my2[RAD_W-1:0];
      sx3  <= sx2;
      sy3  <= sy2;
      vx3  <= vx2;
      vy3  <= vy2;
      r3   <= r2;
    end
  end

  // stage 4: squared distance against squared radius
  logic [SQ_W:0] dsum;
  logic          hit4;

  assign dsum = {1'b0, sqx3} + {1'b0, sqy3};
  assign hit4 = dsum < {{(SQ_W + 1 - D2_W){1'b0}}, rsq3};

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= v3;
    if (en) begin
      d2            <= dsum[D2_W-1:0];
      geo.vel.vx    <= vx3;
      geo.vel.vy    <= vy3;
      geo.vel.sx    <= sx3;
      geo.vel.sy    <= sy3;
      geo.vel.hit   <= hit4;
      geo.vel.emb   <= hit4 && (dsum == '0);
      geo.mag_x     <= mx3;
      geo.mag_y     <= my3;
      geo.radius    <= r3;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/cbc_sqrt.sv -----
`timescale 1ns / 1ps
`default_nettype none
module cbc_sqrt (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic [cbc_pkg::D2_W-1:0]        x,
  input  cbc_pkg::cbc_geo_t               geo_in,
  output logic                            out_valid,
  output logic [cbc_pkg::ROOT_W-1:0]      root,
  output cbc_pkg::cbc_geo_t               geo_out
);
  import cbc_pkg::*;

  logic              v_q    [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic [D2_W-1:0]   rem_q  [ROOT_W];
  cbc_geo_t          geo_q  [ROOT_W];

  // one root bit per stage, most significant first
  for (genvar s = 0; s < ROOT_W; s++) begin : g_st
    localparam int K = ROOT_W - 1 - s;
    logic              v_i;
    logic [ROOT_W-1:0] root_i;
    logic [D2_W-1:0]   rem_i;
    cbc_geo_t          geo_i;
    logic [D2_W:0]     trial, diff;
    logic              ge;

    if (s == 0) begin : g_first
      assign v_i    = in_valid;
      assign root_i = '0;
      assign rem_i  = x;
      assign geo_i  = geo_in;
    end else begin : g_next
      assign v_i    = v_q[s-1];
      assign root_i = root_q[s-1];
      assign rem_i  = rem_q[s-1];
      assign geo_i  = geo_q[s-1];
    end

    assign trial = ({{(D2_W + 1 - ROOT_W){1'b0}}, root_i} << (K + 1))
                 + ({{D2_W{1'b0}}, 1'b1} << (2 * K));
    assign ge    = {1'b0, rem_i} >= trial;
    assign diff  = {1'b0, rem_i} - trial;

    always_ff @(posedge clk) begin
      if (rst) v_q[s] <= 1'b0;
      else if (en) v_q[s] <= v_i;
      if (en) begin
        root_q[s] <= ge ? (root_i | ({{(ROOT_W - 1){1'b0}}, 1'b1} << K)) : root_i;
        rem_q[s]  <= ge ? diff[D2_W-1:0] : rem_i;
        geo_q[s]  <= geo_i;
      end
    end
  end

  assign out_valid = v_q[ROOT_W-1];
  assign root      = root_q[ROOT_W-1];
  assign geo_out   = geo_q[ROOT_W-1];

endmodule
`default_nettype wire

// ----- rtl/core/cbc_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
module cbc_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic [cbc_pkg::NUM_W-1:0]      num_x,
  input  logic [cbc_pkg::NUM_W-1:0]      num_y,
  input  logic [cbc_pkg::ROOT_W-1:0]     den,
  input  cbc_pkg::cbc_vel_t              vel_in,
  output logic                           out_valid,
  output logic [cbc_pkg::NUM_W-1:0]      quo_x,
  output logic [cbc_pkg::NUM_W-1:0]      quo_y,
  output cbc_pkg::cbc_vel_t              vel_out
);
  import cbc_pkg::*;

  logic              v_q   [NUM_W];
  logic [ROOT_W-1:0] den_q [NUM_W];
  logic [ROOT_W-1:0] rx_q  [NUM_W];
  logic [ROOT_W-1:0] ry_q  [NUM_W];
  logic [NUM_W-1:0]  nx_q  [NUM_W];
  logic [NUM_W-1:0]  ny_q  [NUM_W];
  cbc_vel_t          vel_q [NUM_W];

  // restoring division, one quotient bit per stage; the dividend shifts out
  // of the top of nx/ny while quotient bits shift in at the bottom
  for (genvar s = 0; s < NUM_W; s++) begin : g_st
    logic              v_i;
    logic [ROOT_W-1:0] den_i, rx_i, ry_i;
    logic [NUM_W-1:0]  nx_i, ny_i;
    cbc_vel_t          vel_i;
    logic [ROOT_W:0]   shx, shy, dfx, dfy;
    logic              gex, gey;

    if (s == 0) begin : g_first
      assign v_i   = in_valid;
      assign den_i = den;
      assign rx_i  = '0;
      assign ry_i  = '0;
      assign nx_i  = num_x;
      assign ny_i  = num_y;
      assign vel_i = vel_in;
    end else begin : g_next
      assign v_i   = v_q[s-1];
      assign den_i = den_q[s-1];
      assign rx_i  = rx_q[s-1];
      assign ry_i  = ry_q[s-1];
      assign nx_i  = nx_q[s-1];
      assign ny_i  = ny_q[s-1];
      assign vel_i = vel_q[s-1];
    end

    assign shx = {rx_i, nx_i[NUM_W-1]};
    assign shy = {ry_i, ny_i[NUM_W-1]};
    assign gex = shx >= {1'b0, den_i};
    assign gey = shy >= {1'b0, den_i};
    assign dfx = shx - {1'b0, den_i};
    assign dfy = shy - {1'b0, den_i};

    always_ff @(posedge clk) begin
      if (rst) v_q[s] <= 1'b0;
      else if (en) v_q[s] <= v_i;
      if (en) begin
        den_q[s] <= den_i;
        rx_q[s]  <= gex ? dfx[ROOT_W-1:0] : shx[ROOT_W-1:0];
        ry_q[s]  <= gey ? dfy[ROOT_W-1:0] : shy[ROOT_W-1:0];
        nx_q[s]  <= {nx_i[NUM_W-2:0], gex};
        ny_q[s]  <= {ny_i[NUM_W-2:0], gey};
        vel_q[s] <= vel_i;
      end
    end
  end

  assign out_valid = v_q[NUM_W-1];
  assign quo_x     = nx_q[NUM_W-1];
  assign quo_y     = ny_q[NUM_W-1];
  assign vel_out   = vel_q[NUM_W-1];

endmodule
`default_nettype wire

// ----- rtl/core/circle_box_collision_push_out.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Circle versus box collision with push-out of the velocity. Fully pipelined:
// one request is taken every cycle unless the output stalls, and each passes
// through 4 geometry stages, a 20-stage square root, 2 scaling stages, a 40-stage
// divider and the output register. The whole pipe holds while a result sits
// unclaimed at the output, so in_ready follows out_ready when the output is
// full. A hit at zero distance sets centre_embedded and passes the velocity
// through unchanged.
module circle_box_collision_push_out (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [cbc_pkg::POS_W-1:0]    circle_x,
  input  logic signed [cbc_pkg::POS_W-1:0]    circle_y,
  input  logic signed [cbc_pkg::VEL_W-1:0]    vel_x,
  input  logic signed [cbc_pkg::VEL_W-1:0]    vel_y,
  input  logic        [cbc_pkg::SIZE_W-1:0]   circle_w,
  input  logic        [cbc_pkg::SIZE_W-1:0]   circle_h,
  input  logic signed [cbc_pkg::POS_W-1:0]    box_x,
  input  logic signed [cbc_pkg::POS_W-1:0]    box_y,
  input  logic        [cbc_pkg::SIZE_W-1:0]   box_w,
  input  logic        [cbc_pkg::SIZE_W-1:0]   box_h,
  input  logic        [cbc_pkg::RAD_W-1:0]    radius,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                hit,
  output logic                                centre_embedded,
  output logic signed [cbc_pkg::VEL_W-1:0]    new_vel_x,
  output logic signed [cbc_pkg::VEL_W-1:0]    new_vel_y
);
  import cbc_pkg::*;

  localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(2 ** (VEL_W - 1) - 1);
  localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_W'(2 ** (VEL_W - 1));

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  logic            f_valid;
  logic [D2_W-1:0] f_d2;
  cbc_geo_t        f_geo;

  cbc_front u_front (
    .clk, .rst, .en, .in_valid,
    .circle_x, .circle_y, .vel_x, .vel_y, .circle_w, .circle_h,
    .box_x, .box_y, .box_w, .box_h, .radius,
    .out_valid (f_valid),
    .d2        (f_d2),
    .geo       (f_geo)
  );

  logic              s_valid;
  logic [ROOT_W-1:0] s_root;
  cbc_geo_t          s_geo;

  cbc_sqrt u_sqrt (
    .clk, .rst, .en,
    .in_valid  (f_valid),
    .x         (f_d2),
    .geo_in    (f_geo),
    .out_valid (s_valid),
    .root      (s_root),
    .geo_out   (s_geo)
  );

  // span = radius - distance; distance is below radius on a hit
  logic              va, vb;
  logic [RAD_W-1:0]  span_a, mx_a, my_a;
  logic [ROOT_W-1:0] l_a, l_b;
  cbc_vel_t          vel_a, vel_b;
  logic [NUM_W-1:0]  px_b, py_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else if (en) begin
      va <= s_valid;
      vb <= va;
    end
    if (en) begin
      span_a <= s_geo.radius - s_root;
      mx_a   <= s_geo.mag_x;
      my_a   <= s_geo.mag_y;
      l_a    <= s_root;
      vel_a  <= s_geo.vel;
      px_b   <= mx_a * span_a;
      py_b   <= my_a * span_a;
      l_b    <= l_a;
      vel_b  <= vel_a;
    end
  end

  logic             d_valid;
  logic [NUM_W-1:0] qx, qy;
  cbc_vel_t         d_vel;

  cbc_div u_div (
    .clk, .rst, .en,
    .in_valid  (vb),
    .num_x     (px_b),
    .num_y     (py_b),
    .den       (l_b),
    .vel_in    (vel_b),
    .out_valid (d_valid),
    .quo_x     (qx),
    .quo_y     (qy),
    .vel_out   (d_vel)
  );

  // drop the fraction of the correction, apply its sign, saturate
  logic signed [SUM_W-1:0] vxe, vye, cx, cy, sumx, sumy;
  logic signed [VEL_W-1:0] satx, saty;
  logic                    apply;

  assign vxe   = {{(SUM_W - VEL_W){d_vel.vx[VEL_W-1]}}, d_vel.vx};
  assign vye   = {{(SUM_W - VEL_W){d_vel.vy[VEL_W-1]}}, d_vel.vy};
  assign cx    = $signed({2'b00, qx[NUM_W-1:FRAC_W], {FRAC_W{1'b0}}});
  assign cy    = $signed({2'b00, qy[NUM_W-1:FRAC_W], {FRAC_W{1'b0}}});
  assign sumx  = d_vel.sx ? vxe + cx : vxe - cx;
  assign sumy  = d_vel.sy ? vye + cy : vye - cy;
  assign apply = d_vel.hit && !d_vel.emb;

  always_comb begin
    priority if (sumx > SUM_MAX) satx = SUM_MAX[VEL_W-1:0];
    else if (sumx < SUM_MIN)     satx = SUM_MIN[VEL_W-1:0];
    else                         satx = sumx[VEL_W-1:0];
    priority if (sumy > SUM_MAX) saty = SUM_MAX[VEL_W-1:0];
    else if (sumy < SUM_MIN)     saty = SUM_MIN[VEL_W-1:0];
    else                         saty = sumy[VEL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= d_valid;
    if (en) begin
      hit             <= d_vel.hit;
      centre_embedded <= d_vel.emb;
      new_vel_x       <= apply ? satx : d_vel.vx;
      new_vel_y       <= apply ? saty : d_vel.vy;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/cbc_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "circle_box_collision_push_out_defines.svh"
module cbc_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic                              hit,
  input logic                              centre_embedded,
  input logic signed [cbc_pkg::VEL_W-1:0]  new_vel_x,
  input logic signed [cbc_pkg::VEL_W-1:0]  new_vel_y
);

  // a stalled result holds
  `CBC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(centre_embedded) && $stable(new_vel_x) && $stable(new_vel_y))

  // embedded only ever comes with a hit
  `CBC_ASSERT(a_emb_hit, out_valid && centre_embedded |-> hit)

  // an empty output never blocks a request
  `CBC_ASSERT(a_ready_empty, !out_valid |-> in_ready)

  // nothing comes out right after reset
  `CBC_ASSERT_RST(a_reset_empty, $past(rst) |-> !out_valid)

endmodule

bind circle_box_collision_push_out cbc_checker u_cbc_checker (.*);
`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
module tb;
  import cbc_pkg::*;

  typedef struct {
    logic signed [POS_W-1:0]  cx, cy;
    logic signed [VEL_W-1:0]  vx, vy;
    logic        [SIZE_W-1:0] cw, ch;
    logic signed [POS_W-1:0]  bx, by;
    logic        [SIZE_W-1:0] bw, bh;
    logic        [RAD_W-1:0]  r;
  } probe_t;

  typedef struct {
    logic                    hit;
    logic                    emb;
    logic signed [VEL_W-1:0] vx;
    logic signed [VEL_W-1:0] vy;
  } push_t;

  typedef struct {
    probe_t q;
    bit     typed;
    push_t  res;
  } row_t;

  localparam int RANDOM_PROBES = 700;
  localparam int HOLD_CYCLES   = 400;
  localparam longint VMAX = 524287;
  localparam longint VMIN = -524288;

  logic clk = 0, rst = 1;
  logic in_valid = 0, out_ready = 0;
  logic in_ready, out_valid, hit, centre_embedded;
  logic signed [POS_W-1:0]  circle_x = 0, circle_y = 0, box_x = 0, box_y = 0;
  logic signed [VEL_W-1:0]  vel_x = 0, vel_y = 0, new_vel_x, new_vel_y;
  logic        [SIZE_W-1:0] circle_w = 0, circle_h = 0, box_w = 0, box_h = 0;
  logic        [RAD_W-1:0]  radius = 0;

  push_t pending_q[$];
  int errors = 0, n_req = 0, n_res = 0, n_hit = 0, n_emb = 0, n_sat = 0;
  bit hold_req = 0, burst = 0;

  circle_box_collision_push_out i_dut (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("Mismatches found");
    $finish;
  end

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res = 0, b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint push_amount(longint d, longint unsigned span,
                                         longint unsigned l);
    longint unsigned m = (d < 0) ? -d : d;
    longint unsigned q;
    q = ((m * span) / l) & ~64'd255;
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clip_vel(longint v);
    return (v > VMAX) ? VMAX : (v < VMIN) ? VMIN : v;
  endfunction

  function automatic push_t push_out(probe_t q);
    push_t o;
    longint pcx, pcy, nx, ny, dx, dy, fx, fy;
    longint unsigned d2, rr, l;
    pcx = longint'(q.cx) + longint'(q.vx) + (longint'(q.cw >> 1) <<< 8);
    pcy = longint'(q.cy) + longint'(q.vy) + (longint'(q.ch >> 1) <<< 8);
    nx = pcx < q.bx ? q.bx : pcx;
    if (nx > longint'(q.bx) + (longint'(q.bw) <<< 8)) nx = longint'(q.bx) + (longint'(q.bw) <<< 8);
    ny = pcy < q.by ? q.by : pcy;
    if (ny > longint'(q.by) + (longint'(q.bh) <<< 8)) ny = longint'(q.by) + (longint'(q.bh) <<< 8);
    dx = nx - pcx;
    dy = ny - pcy;
    d2 = dx * dx + dy * dy;
    rr = longint'(q.r) * longint'(q.r);
    o.hit = d2 < rr;
    o.emb = o.hit && d2 == 0;
    fx = q.vx;
    fy = q.vy;
    if (o.hit && !o.emb) begin
      l = root_floor(d2);
      fx = clip_vel(fx - push_amount(dx, longint'(q.r) - l, l));
      fy = clip_vel(fy - push_amount(dy, longint'(q.r) - l, l));
    end
    o.vx = fx[VEL_W-1:0];
    o.vy = fy[VEL_W-1:0];
    return o;
  endfunction

  function automatic probe_t rand_probe();
    probe_t q;
    int span_x, span_y;
    longint tx, ty;
    if ($urandom_range(0, 9) == 0) begin
      {q.cx, q.cy} = {$urandom(), $urandom()};
      {q.vx, q.vy} = {$urandom(), $urandom()};
      {q.cw, q.ch, q.bw, q.bh} = {$urandom(), $urandom()};
      {q.bx, q.by} = {$urandom(), $urandom()};
      q.r = $urandom();
      return q;
    end
    q.bx = int'($urandom_range(0, 1 << 23)) - (1 << 22);
    q.by = int'($urandom_range(0, 1 << 23)) - (1 << 22);
    q.bw = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 255);
    q.bh = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 255);
    q.r = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(1, 1 << 16);
    q.cw = $urandom_range(0, 127);
    q.ch = $urandom_range(0, 127);
    case ($urandom_range(0, 5))
      0: q.vx = VMAX;
      1: q.vx = VMIN;
      default: q.vx = int'($urandom_range(0, 1 << 16)) - (1 << 15);
    endcase
    case ($urandom_range(0, 5))
      0: q.vy = VMIN;
      1: q.vy = VMAX;
      default: q.vy = int'($urandom_range(0, 1 << 16)) - (1 << 15);
    endcase
    // aim the center just around the box, within about one radius
    span_x = (int'(q.bw) << 8) + 2 * int'(q.r);
    span_y = (int'(q.bh) << 8) + 2 * int'(q.r);
    tx = longint'(q.bx) - q.r + $urandom_range(0, span_x);
    ty = longint'(q.by) - q.r + $urandom_range(0, span_y);
    q.cx = tx - q.vx - (longint'(q.cw >> 1) <<< 8);
    q.cy = ty - q.vy - (longint'(q.ch >> 1) <<< 8);
    return q;
  endfunction

  task automatic report(string what, longint got, longint want);
    errors++;
    $display("%0t request result %0d: %s got %0d expected %0d", $realtime, n_res, what,
             got, want);
  endtask

  task automatic send(probe_t q, bit typed, push_t res);
    int gap;
    @(negedge clk);
    {circle_x, circle_y, vel_x, vel_y} = {q.cx, q.cy, q.vx, q.vy};
    {circle_w, circle_h, box_x, box_y} = {q.cw, q.ch, q.bx, q.by};
    {box_w, box_h, radius} = {q.bw, q.bh, q.r};
    in_valid = 1;
    do @(posedge clk); while (!in_ready);
    pending_q.push_back(typed ? res : push_out(q));
    n_req++;
    gap = burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // receiver
  initial begin
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        out_ready = 0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 0;
      end
      stall = burst ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_ready = 0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    push_t e;
    if (!rst && out_valid && out_ready) begin
      n_res++;
      if (pending_q.size() == 0) begin
        report("unexpected result", hit, 0);
      end else begin
        e = pending_q.pop_front();
        if (hit !== e.hit) report("hit", hit, e.hit);
        if (centre_embedded !== e.emb) report("centre_embedded", centre_embedded, e.emb);
        if (new_vel_x !== e.vx) report("new_vel_x", new_vel_x, e.vx);
        if (new_vel_y !== e.vy) report("new_vel_y", new_vel_y, e.vy);
        n_hit += e.hit;
        n_emb += e.emb;
        n_sat += (e.vx == VMAX || e.vx == VMIN || e.vy == VMAX || e.vy == VMIN);
      end
    end
  end

  initial begin
    row_t rows[$];
    probe_t z;
    push_t none;
    int w;
    z = '{cx: 0, cy: 0, vx: 0, vy: 0, cw: 0, ch: 0, bx: 0, by: 0, bw: 0, bh: 0, r: 0};
    none = '{hit: 0, emb: 0, vx: 0, vy: 0};
    // zero radius never hits, velocity passes through
    rows.push_back('{z, 1, none});
    rows.push_back('{'{cx: 24'h7fffff, cy: 24'h7fffff, vx: VMAX, vy: VMAX, cw: 12'hfff,
                      ch: 12'hfff, bx: 24'h7fffff, by: 24'h7fffff, bw: 12'hfff,
                      bh: 12'hfff, r: 0}, 1, '{0, 0, VMAX, VMAX}});
    rows.push_back('{'{cx: 24'h800000, cy: 24'h800000, vx: VMIN, vy: VMIN, cw: 0, ch: 0,
                      bx: 24'h800000, by: 24'h800000, bw: 0, bh: 0, r: 0}, 1,
                     '{0, 0, VMIN, VMIN}});
    // center inside the box: embedded, no correction
    rows.push_back('{'{cx: 0, cy: 0, vx: 256, vy: -256, cw: 4, ch: 4, bx: 0, by: 0,
                      bw: 10, bh: 10, r: 256}, 1, '{1, 1, 256, -256}});
    rows.push_back('{'{cx: 0, cy: 0, vx: 0, vy: 0, cw: 0, ch: 0, bx: 0, by: 0, bw: 0,
                      bh: 0, r: 20'hfffff}, 1, '{1, 1, 0, 0}});
    // far apart with the largest radius
    rows.push_back('{'{cx: 24'h800000, cy: 24'h800000, vx: 0, vy: 0, cw: 0, ch: 0,
                      bx: 24'h7fffff, by: 24'h7fffff, bw: 12'hfff, bh: 12'hfff,
                      r: 20'hfffff}, 1, none});
    // touching edges, corners, saturating pushes: predictor checked
    rows.push_back('{'{cx: -1000, cy: 500, vx: 0, vy: 0, cw: 0, ch: 0, bx: 0, by: 0,
                      bw: 8, bh: 8, r: 2000}, 0, none});
    rows.push_back('{'{cx: -2000, cy: -2000, vx: 0, vy: 0, cw: 2, ch: 2, bx: 0, by: 0,
                      bw: 8, bh: 8, r: 3000}, 0, none});
    rows.push_back('{'{cx: 3000, cy: 1000, vx: VMAX, vy: VMIN, cw: 0, ch: 0, bx: 0, by: 0,
                      bw: 8, bh: 8, r: 20'hfffff}, 0, none});
    rows.push_back('{'{cx: -3000, cy: -1000, vx: VMIN, vy: VMAX, cw: 0, ch: 0, bx: 0,
                      by: 0, bw: 8, bh: 8, r: 20'hfffff}, 0, none});
    rows.push_back('{'{cx: -256, cy: 0, vx: 0, vy: 0, cw: 0, ch: 0, bx: 0, by: 0, bw: 1,
                      bh: 1, r: 256}, 0, none});
    rows.push_back('{'{cx: -255, cy: 0, vx: 0, vy: 0, cw: 0, ch: 0, bx: 0, by: 0, bw: 1,
                      bh: 1, r: 256}, 0, none});
    rows.push_back('{'{cx: 24'h7fffff, cy: 24'h7fffff, vx: VMAX, vy: VMAX, cw: 12'hfff,
                      ch: 12'hfff, bx: 0, by: 0, bw: 0, bh: 0, r: 20'hfffff}, 0, none});
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 0;
    foreach (rows[i]) send(rows[i].q, rows[i].typed, rows[i].res);
    for (int k = 0; k < RANDOM_PROBES; k++) begin
      if (k % 50 == 0) burst = ($urandom_range(0, 3) == 0);
      if (k == 300) begin
        burst = 1;
        hold_req = 1;
      end
      if (k == 500) begin
        @(negedge clk);
        in_valid = 0;
        wait (pending_q.size() == 0);
      end
      send(rand_probe(), 0, none);
    end
    @(negedge clk);
    in_valid = 0;
    burst = 0;
    w = 0;
    while (pending_q.size() != 0 && w < 20000) begin
      @(posedge clk);
      w++;
    end
    repeat (100) @(posedge clk);
    $display("%0d requests, %0d results: %0d hits, %0d embedded, %0d saturated velocities",
             n_req, n_res, n_hit, n_emb, n_sat);
    $display("incl. long output hold-off and a full drain pause; %0d errors", errors);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
